// ----- sv/assert_macros.svh -----
// assertion macros for the position controller rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock edge, off while reset is low
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be true at a clock edge
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_CLK(lbl, !(cond), msg)

`endif

// ----- sv/pmd_pkg.sv -----
// shared types, constants and the microcode rom of the position controller
// no dependencies; used by pmd_seq and pid_position_motor_drive_unit
`timescale 1ns / 1ps
`default_nettype none

package pmd_pkg;

	// field and datapath widths
	localparam int unsigned COUNT_W   = 24;
	localparam int unsigned GAIN_W    = 24;
	localparam int unsigned ANGLE_W   = 17;
	localparam int unsigned DUTY_W    = 7;
	localparam int unsigned DIR_W     = 2;
	localparam int unsigned ERR_W     = 28;
	localparam int unsigned DERR_W    = 29;
	localparam int unsigned Q_W       = 27;
	localparam int unsigned Y_W       = 32;
	localparam int unsigned INTEG_W   = 48;
	localparam int unsigned U_W       = 64;
	localparam int unsigned OPND_W    = 33;
	localparam int unsigned PROD_W    = 66;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 24;
	localparam int unsigned PC_W      = 4;
	localparam int unsigned DUTY_LSB  = 24;

	// position scaling: pos = floor((384*|count| + 17) / 35)
	localparam logic [Y_W-1:0]    ROUND_BIAS  = 32'd17;
	localparam logic [Y_W:0]      DIVISOR     = 33'd35;
	localparam logic [OPND_W-1:0] RECIP_35    = 33'd3926827242;
	localparam int unsigned       RECIP_SHIFT = 37;

	// sample period 0.005 s in Q0.24
	localparam logic [OPND_W-1:0] T_Q24 = 33'd83886;

	localparam logic [DUTY_W-1:0] DUTY_CAP = 7'd99;

	// register reset values
	localparam logic [GAIN_W-1:0]  KP_RESET    = 24'd192676;
	localparam logic [GAIN_W-1:0]  KI_RESET    = 24'd0;
	localparam logic [GAIN_W-1:0]  KD_RESET    = 24'd0;
	localparam logic [ANGLE_W-1:0] TARGET_RESET = 17'd23040;
	localparam logic [ANGLE_W-1:0] FLOOR_RESET  = 17'd15360;
	localparam logic [ANGLE_W-1:0] CEIL_RESET   = 17'd30720;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP     = 3'd0,
		CFG_KI     = 3'd1,
		CFG_KD     = 3'd2,
		CFG_TARGET = 3'd3,
		CFG_FLOOR  = 3'd4,
		CFG_CEIL   = 3'd5
	} cfg_idx_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_NONE = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	// register-write operation of one step
	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLAMP,
		OP_QEST,
		OP_QINC,
		OP_ERR,
		OP_INTEG,
		OP_LOADP,
		OP_SCALE,
		OP_ADDD,
		OP_ADDI,
		OP_OUT
	} uop_t;

	// multiplier operand pair launched by one step
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_RECIP,
		MUL_ET,
		MUL_KP,
		MUL_KD,
		MUL_KI
	} mul_sel_t;

	typedef enum logic {
		COND_NEVER,
		COND_REM_LOW
	} cond_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef struct packed {
		uop_t            op;
		mul_sel_t        mul;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            last;
	} ucode_t;

	// sequencer to datapath
	typedef struct packed {
		logic     fire;
		uop_t     op;
		mul_sel_t mul;
	} seq_ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic start;
		logic rem_low;
		logic out_hold;
	} seq_stat_t;

	// control program, one word per step
	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{op: OP_NOP, mul: MUL_NONE, cond: COND_NEVER, target: '0, last: 1'b0};
		unique case (pc)
			4'd0:  begin w.op = OP_CLAMP; w.mul = MUL_RECIP; end
			4'd1:  begin w.op = OP_QEST; end
			4'd2:  begin w.cond = COND_REM_LOW; w.target = 4'd4; end
			4'd3:  begin w.op = OP_QINC; end
			4'd4:  begin w.op = OP_ERR; end
			4'd5:  begin w.mul = MUL_ET; end
			4'd6:  begin w.op = OP_INTEG; w.mul = MUL_KP; end
			4'd7:  begin w.op = OP_LOADP; w.mul = MUL_KD; end
			4'd8:  begin w.op = OP_SCALE; w.mul = MUL_KI; end
			4'd9:  begin w.op = OP_ADDD; end
			4'd10: begin w.op = OP_ADDI; end
			4'd11: begin w.op = OP_OUT; w.last = 1'b1; end
			default: begin w.last = 1'b1; end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- sv/pmd_seq.sv -----
// microcode sequencer: step counter, rom fetch and conditional jump
// depends on pmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pmd_seq (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire pmd_pkg::seq_stat_t stat,
	output pmd_pkg::seq_ctrl_t ctrl,
	output logic               busy
);

	pmd_pkg::seq_state_t           state_q, state_d;
	logic [pmd_pkg::PC_W-1:0]      pc_q, pc_d;
	pmd_pkg::ucode_t               uw;
	logic                          cond_hit;

	assign uw = pmd_pkg::ucode(pc_q);

	always_comb begin
		unique case (uw.cond)
			pmd_pkg::COND_REM_LOW: cond_hit = stat.rem_low;
			default:               cond_hit = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		pc_d    = pc_q;
		unique case (state_q)
			pmd_pkg::SEQ_IDLE: begin
				if (stat.start) begin
					state_d = pmd_pkg::SEQ_RUN;
					pc_d    = '0;
				end
			end
			pmd_pkg::SEQ_RUN: begin
				if (uw.last) begin
					if (!stat.out_hold) begin
						state_d = pmd_pkg::SEQ_IDLE;
					end
				end else if (cond_hit) begin
					pc_d = uw.target;
				end else begin
					pc_d = pc_q + 1'b1;
				end
			end
			default: begin
				state_d = pmd_pkg::SEQ_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy      = (state_q == pmd_pkg::SEQ_RUN);
		ctrl.fire = (state_q == pmd_pkg::SEQ_RUN) && !(uw.last && stat.out_hold);
		ctrl.op   = uw.op;
		ctrl.mul  = uw.mul;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmd_pkg::SEQ_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/pid_position_motor_drive_unit.sv -----
// pid position controller top level: config registers, datapath, output register
// depends on pmd_pkg, pmd_seq and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// channel   | direction | contents
// s_axis    | in        | encoder_count, one per control tick
// m_axis    | out       | cw_duty, ccw_duty, turn_dir, one per tick
// cfg       | in        | write-only register port, six gain and angle registers
//
// s_axis_tready is low while the microcode program runs after an input transfer
// (shorter when the position quotient estimate needs no correction), so a new
// tick is accepted only after the previous one has left the program; the
// twelve-step microcode program around one shared 33x33 multiplier sets this
// reset clears the registers to their defaults and the controller state to zero
// a finished result waits in the output register; the next tick is taken
// meanwhile and its last step stalls only while that result is still untaken

module pid_position_motor_drive_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// config write port
	input  wire logic                                cfg_wen,
	input  wire logic [pmd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pmd_pkg::CFG_W-1:0]           cfg_wdata,
	// input stream
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [23:0]                         s_axis_tdata,  // [23:0] encoder_count
	// output stream
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [15:0]                              m_axis_tdata   // [6:0] cw_duty,
	                                                                // [13:7] ccw_duty,
	                                                                // [15:14] turn_dir
);

	localparam int unsigned COUNT_W = pmd_pkg::COUNT_W;
	localparam int unsigned ANGLE_W = pmd_pkg::ANGLE_W;
	localparam int unsigned GAIN_W  = pmd_pkg::GAIN_W;
	localparam int unsigned ERR_W   = pmd_pkg::ERR_W;
	localparam int unsigned DERR_W  = pmd_pkg::DERR_W;
	localparam int unsigned Q_W     = pmd_pkg::Q_W;
	localparam int unsigned Y_W     = pmd_pkg::Y_W;
	localparam int unsigned INTEG_W = pmd_pkg::INTEG_W;
	localparam int unsigned U_W     = pmd_pkg::U_W;
	localparam int unsigned OPND_W  = pmd_pkg::OPND_W;
	localparam int unsigned PROD_W  = pmd_pkg::PROD_W;
	localparam int unsigned DUTY_W  = pmd_pkg::DUTY_W;
	localparam int unsigned HI_W    = U_W - pmd_pkg::DUTY_LSB;

	// ---------------------------------------------------------------- config
	logic [GAIN_W-1:0]  kp_q, ki_q, kd_q;
	logic [ANGLE_W-1:0] target_q, floor_q, ceil_q;
	logic [ANGLE_W-1:0] clamp_w;

	// ---------------------------------------------------------------- sequencer
	pmd_pkg::seq_ctrl_t ctrl;
	pmd_pkg::seq_stat_t stat;
	logic               busy;

	// ---------------------------------------------------------------- datapath
	logic                 neg_q;     // encoder count below zero
	logic [Y_W-1:0]       y_q;       // 384*|count| + 17
	logic [Q_W-1:0]       q_q;       // |position| in degrees q.8
	logic [ERR_W-1:0]     e_q;       // error of this tick
	logic [ERR_W-1:0]     last_q;    // error of the previous tick
	logic [INTEG_W-1:0]   integ_q;   // error integral, q.32
	logic signed [PROD_W-1:0] prod_q;
	logic signed [U_W-1:0]    u_q;   // control output, q.24 percent
	logic signed [U_W-1:0]    d_q;   // derivative term

	logic [COUNT_W-1:0]   cnt_mag_w;
	logic [Y_W-1:0]       y_w;
	logic [Y_W:0]         q35_w, rem_w;
	logic [DERR_W-1:0]    de_w;
	logic signed [OPND_W-1:0] opa_w, opb_w;
	logic signed [PROD_W-1:0] prod_w;
	logic [INTEG_W:0]     integ_sum_w;
	logic [INTEG_W-1:0]   integ_w;
	logic signed [U_W-1:0]    p64_w;
	logic [U_W-1:0]       umag_w;
	logic [HI_W-1:0]      duty_hi_w;
	logic [DUTY_W-1:0]    duty_w;

	// ---------------------------------------------------------------- output
	logic                 out_valid_q;
	logic [DUTY_W-1:0]    cw_q, ccw_q;
	pmd_pkg::dir_t        dir_q;

	logic in_xfer, out_xfer, out_fire;

	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_xfer      = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = !busy;
	assign out_fire      = ctrl.fire && (ctrl.op == pmd_pkg::OP_OUT);

	// reference clamp: floor test wins when the window is inverted
	always_comb begin
		priority if (target_q < floor_q) begin
			clamp_w = floor_q;
		end else if (target_q > ceil_q) begin
			clamp_w = ceil_q;
		end else begin
			clamp_w = target_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= pmd_pkg::KP_RESET;
			ki_q     <= pmd_pkg::KI_RESET;
			kd_q     <= pmd_pkg::KD_RESET;
			target_q <= pmd_pkg::TARGET_RESET;
			floor_q  <= pmd_pkg::FLOOR_RESET;
			ceil_q   <= pmd_pkg::CEIL_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				pmd_pkg::CFG_KP:     kp_q     <= cfg_wdata;
				pmd_pkg::CFG_KI:     ki_q     <= cfg_wdata;
				pmd_pkg::CFG_KD:     kd_q     <= cfg_wdata;
				pmd_pkg::CFG_TARGET: target_q <= cfg_wdata[ANGLE_W-1:0];
				pmd_pkg::CFG_FLOOR:  floor_q  <= cfg_wdata[ANGLE_W-1:0];
				pmd_pkg::CFG_CEIL:   ceil_q   <= cfg_wdata[ANGLE_W-1:0];
				default: ;
			endcase
		end else if (ctrl.fire && (ctrl.op == pmd_pkg::OP_CLAMP)) begin
			// clamped reference is kept for later ticks
			target_q <= clamp_w;
		end
	end

	assign stat = '{
		start:    in_xfer,
		rem_low:  (rem_w < pmd_pkg::DIVISOR),
		out_hold: out_valid_q && !m_axis_tready
	};

	pmd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// magnitude of the count, scaled by 384 plus the rounding bias
	assign cnt_mag_w = s_axis_tdata[COUNT_W-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
	assign y_w = {cnt_mag_w, 8'd0} + {1'b0, cnt_mag_w, 7'd0} + pmd_pkg::ROUND_BIAS;

	// remainder check of the reciprocal estimate: y - 35*q
	assign q35_w = {1'b0, q_q, 5'd0} + {5'd0, q_q, 1'b0} + {6'd0, q_q};
	assign rem_w = {1'b0, y_q} - q35_w;

	assign de_w = {e_q[ERR_W-1], e_q} - {last_q[ERR_W-1], last_q};

	// shared multiplier operand selection
	always_comb begin
		unique case (ctrl.mul)
			pmd_pkg::MUL_RECIP: begin
				opa_w = {1'b0, y_q};
				opb_w = pmd_pkg::RECIP_35;
			end
			pmd_pkg::MUL_ET: begin
				opa_w = {{(OPND_W-ERR_W){e_q[ERR_W-1]}}, e_q};
				opb_w = pmd_pkg::T_Q24;
			end
			pmd_pkg::MUL_KP: begin
				opa_w = {{(OPND_W-GAIN_W){1'b0}}, kp_q};
				opb_w = {{(OPND_W-ERR_W){e_q[ERR_W-1]}}, e_q};
			end
			pmd_pkg::MUL_KD: begin
				opa_w = {{(OPND_W-GAIN_W){1'b0}}, kd_q};
				opb_w = {{(OPND_W-DERR_W){de_w[DERR_W-1]}}, de_w};
			end
			pmd_pkg::MUL_KI: begin
				// integral floored to q.16
				opa_w = {{(OPND_W-GAIN_W){1'b0}}, ki_q};
				opb_w = {integ_q[INTEG_W-1], integ_q[INTEG_W-1:16]};
			end
			default: begin
				opa_w = '0;
				opb_w = '0;
			end
		endcase
	end

	assign prod_w = opa_w * opb_w;

	// saturating integrator update, product holds e*T
	assign integ_sum_w = {integ_q[INTEG_W-1], integ_q} + prod_q[INTEG_W:0];
	always_comb begin
		priority if (integ_sum_w[INTEG_W] == integ_sum_w[INTEG_W-1]) begin
			integ_w = integ_sum_w[INTEG_W-1:0];
		end else if (integ_sum_w[INTEG_W]) begin
			integ_w = {1'b1, {(INTEG_W-1){1'b0}}};
		end else begin
			integ_w = {1'b0, {(INTEG_W-1){1'b1}}};
		end
	end

	assign p64_w = prod_q[U_W-1:0];

	// duty from |u| in q.24, capped
	assign umag_w    = u_q[U_W-1] ? (~u_q + 1'b1) : u_q;
	assign duty_hi_w = umag_w[U_W-1:pmd_pkg::DUTY_LSB];
	assign duty_w    = (duty_hi_w > {{(HI_W-DUTY_W){1'b0}}, pmd_pkg::DUTY_CAP}) ?
	                   pmd_pkg::DUTY_CAP : duty_hi_w[DUTY_W-1:0];

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.fire && (ctrl.op == pmd_pkg::OP_INTEG)) begin
				integ_q <= integ_w;
			end
			if (out_fire) begin
				last_q      <= e_q;
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			neg_q <= s_axis_tdata[COUNT_W-1];
			y_q   <= y_w;
		end
		if (ctrl.fire && (ctrl.mul != pmd_pkg::MUL_NONE)) begin
			prod_q <= prod_w;
		end
		if (ctrl.fire) begin
			unique case (ctrl.op)
				pmd_pkg::OP_QEST:  q_q <= prod_q[pmd_pkg::RECIP_SHIFT +: Q_W];
				pmd_pkg::OP_QINC:  q_q <= q_q + 1'b1;
				pmd_pkg::OP_ERR: begin
					// e = reference - position, position carries the count sign
					if (neg_q) begin
						e_q <= {{(ERR_W-ANGLE_W){1'b0}}, target_q} + {1'b0, q_q};
					end else begin
						e_q <= {{(ERR_W-ANGLE_W){1'b0}}, target_q} - {1'b0, q_q};
					end
				end
				pmd_pkg::OP_LOADP: u_q <= p64_w;
				// derivative divides by T as a multiply by 200
				pmd_pkg::OP_SCALE: d_q <= (p64_w <<< 7) + (p64_w <<< 6) + (p64_w <<< 3);
				pmd_pkg::OP_ADDD:  u_q <= u_q + d_q;
				pmd_pkg::OP_ADDI:  u_q <= u_q + (p64_w >>> 8);
				pmd_pkg::OP_OUT: begin
					priority if (u_q == '0) begin
						cw_q  <= '0;
						ccw_q <= '0;
						dir_q <= pmd_pkg::DIR_NONE;
					end else if (!u_q[U_W-1]) begin
						cw_q  <= duty_w;
						ccw_q <= '0;
						dir_q <= pmd_pkg::DIR_CW;
					end else begin
						cw_q  <= '0;
						ccw_q <= duty_w;
						dir_q <= pmd_pkg::DIR_CCW;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {dir_q, ccw_q, cw_q};

	// ---------------------------------------------------------------- checks
	`ASSERT_CLK(a_duty_capped, m_axis_tvalid |-> ((cw_q <= pmd_pkg::DUTY_CAP) && (ccw_q <= pmd_pkg::DUTY_CAP)), "duty above cap")
	`ASSERT_NEVER(a_both_sides, m_axis_tvalid && (cw_q != '0) && (ccw_q != '0), "both drive sides active")
	`ASSERT_CLK(a_dir_none_idle, (m_axis_tvalid && (dir_q == pmd_pkg::DIR_NONE)) |-> ((cw_q == '0) && (ccw_q == '0)), "duty without direction")
	`ASSERT_CLK(a_one_tick, in_xfer |=> (busy && !s_axis_tready), "sequencer not started by transfer")

endmodule

`default_nettype wire
